FILE: hw/rtl/sbs_pkg.sv
// Shared constants and types for the spectrum bin statistics block.
package sbs_pkg;
   localparam int Bins = 80;
   localparam int PointsPerBin = 3;
   localparam int BinW = 7;
   localparam logic [0:0] RegSweeps = 1'b0;
   localparam logic [0:0] RegFloor = 1'b1;

   typedef struct packed {
      logic        start;
      logic [15:0] mean_sum;
      logic [23:0] sq_sum;
      logic [8:0]  count;
   } div_req_type;

   typedef struct packed {
      logic [7:0] average;
      logic [6:0] spread;
   } div_rsp_type;
endpackage

FILE: hw/rtl/sbs_stat_unit.sv
// Iterative divide and square root that turns one bin's sums into average and spread.
module sbs_stat_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  sbs_pkg::div_req_type      req,
   output logic                      done,
   output sbs_pkg::div_rsp_type      rsp
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_DIV1 = 5'b00010, S_DIV2 = 5'b00100,
      S_ROOT = 5'b01000, S_DONE = 5'b10000
   } st_type;

   st_type      state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        neg_ff, neg_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [23:0] q2_ff, q2_in;
   logic [23:0] r2_ff, r2_in;
   logic [8:0]  n_ff, n_in;
   logic [10:0] n3_ff, n3_in;
   logic [23:0] sq_ff, sq_in;
   logic [7:0]  avg_ff, avg_in;
   logic [23:0] var_ff, var_in;
   logic [11:0] root_ff, root_in;

   logic [16:0] r1;
   logic [24:0] r2t;
   logic [11:0] cand;
   logic [23:0] cand_sq;
   logic signed [16:0] sq_avg;
   logic signed [16:0] s_avg;
   logic signed [24:0] var_s;

   always_comb begin
      state_in = state_ff; step_in = step_ff; neg_in = neg_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvd_in = dvd_ff;
      q2_in = q2_ff; r2_in = r2_ff; n_in = n_ff; n3_in = n3_ff; sq_in = sq_ff;
      avg_in = avg_ff; var_in = var_ff; root_in = root_ff;
      r1 = '0; r2t = '0; cand = '0; cand_sq = '0; s_avg = '0; sq_avg = '0; var_s = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               neg_in = req.mean_sum[15];
               dvd_in = req.mean_sum[15] ? 16'(-req.mean_sum) : req.mean_sum;
               sq_in = req.sq_sum;
               n_in = req.count;
               n3_in = 11'(req.count) * 11'(sbs_pkg::PointsPerBin);
               quo_in = '0; rem_in = '0; q2_in = '0; r2_in = '0;
               step_in = 5'd0;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            // restoring divide, signed mean sum by sweeps, plus square sum by 3n
            r1 = {rem_ff, dvd_ff[15 - step_ff[3:0]]};
            if (r1 >= 17'(n_ff)) begin
               rem_in = 16'(r1 - 17'(n_ff)); quo_in = quo_ff | (16'd1 << (15 - step_ff[3:0]));
            end else begin
               rem_in = r1[15:0];
            end
            r2t = {r2_ff, sq_ff[23 - step_ff]};
            if (r2t >= 25'(n3_ff)) begin
               r2_in = 24'(r2t - 25'(n3_ff)); q2_in = q2_ff | (24'd1 << (23 - step_ff));
            end else begin
               r2_in = r2t[23:0];
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) state_in = S_DIV2;
         end
         S_DIV2: begin
            r2t = {r2_ff, sq_ff[23 - step_ff]};
            if (r2t >= 25'(n3_ff)) begin
               r2_in = 24'(r2t - 25'(n3_ff)); q2_in = q2_ff | (24'd1 << (23 - step_ff));
            end else begin
               r2_in = r2t[23:0];
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd23) begin
               s_avg = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
               if (s_avg > 17'sd127) avg_in = 8'd127;
               else if (s_avg < -17'sd128) avg_in = 8'h80;
               else avg_in = s_avg[7:0];
               step_in = 5'd0; root_in = '0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (step_ff == 5'd0) begin
               sq_avg = 17'($signed(avg_ff) * $signed(avg_ff));
               var_s = $signed({1'b0, q2_ff}) - 25'(sq_avg);
               var_in = var_s[24] ? 24'd0 : var_s[23:0];
               step_in = 5'd1;
            end else begin
               cand = root_ff | (12'd2048 >> (step_ff - 5'd1));
               cand_sq = 24'(cand * cand);
               if (cand_sq <= var_ff) root_in = cand;
               step_in = step_ff + 5'd1;
               if (step_ff == 5'd12) state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; step_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in;
      end
      neg_ff <= neg_in; quo_ff <= quo_in; rem_ff <= rem_in; dvd_ff <= dvd_in;
      q2_ff <= q2_in; r2_ff <= r2_in; n_ff <= n_in; n3_ff <= n3_in; sq_ff <= sq_in;
      avg_ff <= avg_in; var_ff <= var_in; root_ff <= root_in;
   end

   assign done = (state_ff == S_DONE);
   assign rsp.average = avg_ff;
   assign rsp.spread = (root_ff > 12'd127) ? 7'd127 : root_ff[6:0];

`ifndef NO_ASSERTIONS
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("result strobe held");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV1) |-> (step_ff <= 5'd15)) else $error("divide step overran");
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT) |-> (step_ff <= 5'd12)) else $error("root step overran");
`endif
endmodule

FILE: hw/rtl/spectrum_bin_statistics.sv
// Top level of the spectrum bin statistics block.
// Each req word is one sweep point; three points make a bin group and 80 groups a
// sweep. Per-bin peak, mean sum and square sum live in one 80-entry memory that
// is read, updated and written back on each completed group. A point that ends a
// group goes through accept, read and write back before the next point is taken.
// On a reporting sweep a group's last point then goes through the statistics
// unit (16 + 8 bit-serial divide steps, one variance step, 12 square root steps
// and a done state) and is moved into the output register, which waits while an
// earlier result word is still waiting there. After reset a clearing pass writes
// every entry to its cleared value; no point is taken meanwhile. The peak floor
// used for clearing is the register value at the time.
module spectrum_bin_statistics (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] amplitude
   input  logic        req_tuser,   // [0] sweep_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] bin_index, [14:7] bin_peak,
                                    // [22:15] bin_average, [29:23] bin_spread,
                                    // [31:30] zero
   output logic        rsp_tlast,   // last_bin
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_READ = 6'b000100,
      S_UPDATE = 6'b001000, S_STAT = 6'b010000, S_OUT = 6'b100000
   } st_type;

   st_type      state_ff, state_in;
   logic [7:0]  sweeps_ff;
   logic [7:0]  floor_ff;
   logic [6:0]  clr_ff;
   logic [1:0]  pig_ff;
   logic [6:0]  bin_ff;
   logic [7:0]  count_ff;
   logic signed [9:0]  gsum_ff;
   logic signed [7:0]  gpeak_ff;
   logic [15:0] gsq_ff;
   logic [47:0] entry_ff;          // {sq_sum, mean_sum, peak}
   logic [47:0] upd_ff;
   logic        pending_ff;
   logic [6:0]  stage_bin_ff;
   logic [7:0]  stage_peak_ff;
   logic [6:0]  out_bin_ff;
   logic [7:0]  out_peak_ff;
   logic [7:0]  out_avg_ff;
   logic [6:0]  out_spread_ff;
   logic        out_valid_ff;

   logic [47:0] mem [sbs_pkg::Bins];

   // combinational group update
   logic signed [7:0]  amp;
   logic [1:0]  pig_eff;
   logic [6:0]  bin_eff;
   logic signed [15:0] amp_sq;
   logic signed [9:0]  gsum_n;
   logic signed [7:0]  gpeak_n;
   logic [15:0] gsq_n;
   logic        group_end;
   logic        reporting;
   logic [8:0]  gabs;
   logic [17:0] gprod;
   logic [7:0]  gquot;
   logic signed [9:0]  gmean;
   logic signed [7:0]  new_peak;
   logic [15:0] new_mean;
   logic [23:0] new_sq;
   logic        mem_we;
   logic [6:0]  mem_wa;
   logic [47:0] mem_wd;
   logic        accept;
   logic        out_free;
   sbs_pkg::div_req_type dreq;
   sbs_pkg::div_rsp_type drsp;
   logic        ddone;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free = !out_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;
   assign amp = $signed(req_tdata);
   assign pig_eff = req_tuser ? 2'd0 : pig_ff;
   assign bin_eff = (req_tuser || bin_ff >= 7'(sbs_pkg::Bins)) ? 7'd0 : bin_ff;
   assign amp_sq = amp * amp;
   assign reporting = (9'(count_ff) + 9'd1) >= 9'(sweeps_ff);

   always_comb begin
      if (pig_eff == 2'd0) begin
         gsum_n = 10'(amp); gpeak_n = amp; gsq_n = amp_sq;
      end else begin
         gsum_n = gsum_ff + 10'(amp);
         gpeak_n = (amp > gpeak_ff) ? amp : gpeak_ff;
         gsq_n = gsq_ff + amp_sq;
      end
      group_end = (32'(pig_eff) + 1) >= sbs_pkg::PointsPerBin;
   end

   // divide by three toward zero, sign kept: magnitude times 171/512,
   // exact for magnitudes below 512
   always_comb begin
      gabs = gsum_ff[9] ? 9'(-gsum_ff) : gsum_ff[8:0];
      gprod = 18'(gabs) * 18'd171;
      gquot = gprod[16:9];
      gmean = gsum_ff[9] ? -$signed({2'b00, gquot}) : $signed({2'b00, gquot});
      new_peak = (gpeak_ff > $signed(entry_ff[7:0])) ? gpeak_ff : $signed(entry_ff[7:0]);
      new_mean = entry_ff[23:8] + 16'(gmean);
      new_sq = entry_ff[47:24] + 24'(gsq_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == 7'(sbs_pkg::Bins - 1)) state_in = S_IDLE;
         S_IDLE: if (accept && group_end) state_in = S_READ;
         S_READ: state_in = S_UPDATE;
         S_UPDATE: state_in = pending_ff ? S_STAT : S_IDLE;
         S_STAT: if (ddone) state_in = S_OUT;
         // hold here while the previous result word is still unclaimed
         S_OUT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      mem_we = 1'b0; mem_wa = bin_ff; mem_wd = upd_ff;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1; mem_wa = clr_ff; mem_wd = {24'd0, 16'd0, floor_ff};
      end else if (state_ff == S_UPDATE) begin
         mem_we = 1'b1;
         mem_wd = pending_ff ? {24'd0, 16'd0, floor_ff} : upd_ff;
      end
      dreq.start = (state_ff == S_UPDATE) && pending_ff;
      dreq.mean_sum = upd_ff[23:8];
      dreq.sq_sum = upd_ff[47:24];
      dreq.count = 9'(count_ff) + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (state_ff == S_IDLE) entry_ff <= mem[bin_eff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0;
         sweeps_ff <= 8'd31; floor_ff <= 8'h81;
         pig_ff <= '0; bin_ff <= '0; count_ff <= '0;
         out_valid_ff <= 1'b0; pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 7'd1;
         if (csr_valid) begin
            unique case (csr_index)
               sbs_pkg::RegSweeps: sweeps_ff <= csr_data;
               sbs_pkg::RegFloor:  floor_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            gsum_ff <= gsum_n; gpeak_ff <= gpeak_n; gsq_ff <= gsq_n;
            bin_ff <= bin_eff;
            pig_ff <= group_end ? 2'd0 : pig_eff + 2'd1;
         end
         if (state_ff == S_READ) begin
            upd_ff <= {new_sq, new_mean, new_peak};
            pending_ff <= reporting;
         end
         if (state_ff == S_UPDATE) begin
            stage_bin_ff <= bin_ff;
            stage_peak_ff <= upd_ff[7:0];
            if (bin_ff + 7'd1 >= 7'(sbs_pkg::Bins)) begin
               bin_ff <= '0;
               count_ff <= reporting ? 8'd0 : count_ff + 8'd1;
            end else begin
               bin_ff <= bin_ff + 7'd1;
            end
         end
         if (state_ff == S_OUT && out_free) begin
            out_bin_ff <= stage_bin_ff; out_peak_ff <= stage_peak_ff;
            out_avg_ff <= drsp.average; out_spread_ff <= drsp.spread;
            out_valid_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   sbs_stat_unit u_stat (
      .clock(clock), .reset(reset), .req(dreq), .done(ddone), .rsp(drsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {2'b00, out_spread_ff, out_avg_ff, out_peak_ff, out_bin_ff};
   assign rsp_tlast = (out_bin_ff == 7'(sbs_pkg::Bins - 1));

`ifndef NO_ASSERTIONS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("point taken while busy");
   a_out_from_stat: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_OUT)) else $error("stray result");
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> (bin_ff < 7'(sbs_pkg::Bins))) else $error("bin out of range");
`endif
endmodule
